// ===== rtl/tis_pkg.sv =====
// Shared types and constants for the trie insert and search unit.
`timescale 1ns / 1ps
`default_nettype none

package tis_pkg;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_EXACT  = 2'd1;
   localparam logic [1:0] OP_PREFIX = 2'd2;

   typedef struct packed {
      logic clear;
      logic load;
      logic read_link;
      logic update;
      logic finish;
      logic respond;
   } tis_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic last;
   } tis_status_type;

endpackage

`default_nettype wire

// ===== rtl/tis_ctrl.sv =====
// Controller state machine that sequences clearing, link walks and results.
`timescale 1ns / 1ps
`default_nettype none

module tis_ctrl
   import tis_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   output logic                busy,
   output logic                rsp_strobe,
   output tis_cmd_type         cmd,
   input  wire tis_status_type status
);

   localparam logic [2:0] ST_CLEAR   = 3'd0;
   localparam logic [2:0] ST_IDLE    = 3'd1;
   localparam logic [2:0] ST_READ    = 3'd2;
   localparam logic [2:0] ST_UPDATE  = 3'd3;
   localparam logic [2:0] ST_FINISH  = 3'd4;
   localparam logic [2:0] ST_RESPOND = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = status.last ? ST_FINISH : ST_IDLE;
         end
         ST_FINISH: begin
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      busy          = (state_ff != ST_IDLE);
      rsp_strobe    = (state_ff == ST_RESPOND);
      cmd.clear     = (state_ff == ST_CLEAR);
      cmd.load      = (state_ff == ST_IDLE) && start;
      cmd.read_link = (state_ff == ST_READ);
      cmd.update    = (state_ff == ST_UPDATE);
      cmd.finish    = (state_ff == ST_FINISH);
      cmd.respond   = (state_ff == ST_RESPOND);
   end

endmodule

`default_nettype wire

// ===== rtl/tis_datapath.sv =====
// Datapath with the link memory, mark memory, walk registers and result logic.
`timescale 1ns / 1ps
`default_nettype none

module tis_datapath
   import tis_pkg::*;
#(
   parameter int NODE_COUNT    = 1024,
   parameter int ALPHABET_SIZE = 26
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire tis_cmd_type cmd,
   output tis_status_type   status,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [4:0]  req_letter,
   input  wire logic        req_last_letter,
   input  wire logic        req_empty_word,
   output logic             rsp_found,
   output logic             rsp_pool_full
);

   localparam int NODE_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int FREE_W = NODE_W + 1;
   localparam int SLOTS  = NODE_COUNT * ALPHABET_SIZE;
   localparam int SLOT_W = $clog2(SLOTS);

   logic [NODE_W-1:0] link_mem [SLOTS];
   logic              mark_mem [NODE_COUNT];

   logic [SLOT_W-1:0] clr_ff, clr_in;
   logic [NODE_W-1:0] cur_ff, cur_in;
   logic [FREE_W-1:0] next_free_ff, next_free_in;
   logic              missed_ff, missed_in;
   logic              overflow_ff, overflow_in;
   logic              root_mark_ff, root_mark_in;

   logic [1:0]        op_ff;
   logic              last_ff;
   logic              walk_ff;
   logic              bad_letter_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [NODE_W-1:0] link_rd_ff;
   logic              mark_rd_ff;
   logic              root_sel_ff;

   logic              pool_room;
   logic              alloc;
   logic              mark_set;
   logic              mark_ok;
   logic [SLOT_W-1:0] slot_calc;

   assign slot_calc = SLOT_W'(SLOT_W'(cur_ff) * SLOT_W'(ALPHABET_SIZE)) + SLOT_W'(req_letter);
   assign pool_room = (next_free_ff < FREE_W'(NODE_COUNT));
   assign alloc     = cmd.update && walk_ff && !bad_letter_ff && (link_rd_ff == '0)
                      && (op_ff == OP_INSERT) && pool_room;
   assign mark_set  = cmd.finish && (op_ff == OP_INSERT) && !missed_ff;

   assign status.clear_done = (clr_ff == SLOT_W'(SLOTS - 1));
   assign status.last       = last_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff         <= req_opcode;
         last_ff       <= req_last_letter;
         walk_ff       <= !req_empty_word && !missed_ff;
         bad_letter_ff <= (32'(req_letter) >= ALPHABET_SIZE);
         slot_ff       <= slot_calc;
      end
      if (cmd.finish) begin
         root_sel_ff <= (cur_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         link_mem[clr_ff] <= '0;
      end else if (alloc) begin
         link_mem[slot_ff] <= next_free_ff[NODE_W-1:0];
      end
      if (cmd.read_link) begin
         link_rd_ff <= link_mem[slot_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (alloc) begin
         mark_mem[next_free_ff[NODE_W-1:0]] <= 1'b0;
      end else if (mark_set && (cur_ff != '0)) begin
         mark_mem[cur_ff] <= 1'b1;
      end
      if (cmd.finish) begin
         mark_rd_ff <= mark_mem[cur_ff];
      end
   end

   always_comb begin
      clr_in       = clr_ff;
      cur_in       = cur_ff;
      next_free_in = next_free_ff;
      missed_in    = missed_ff;
      overflow_in  = overflow_ff;
      root_mark_in = root_mark_ff;
      if (cmd.clear && !status.clear_done) begin
         clr_in = clr_ff + 1'b1;
      end
      if (cmd.update && walk_ff) begin
         priority if (bad_letter_ff) begin
            missed_in = 1'b1;
         end else if (link_rd_ff != '0) begin
            cur_in = link_rd_ff;
         end else if (op_ff != OP_INSERT) begin
            missed_in = 1'b1;
         end else if (!pool_room) begin
            missed_in   = 1'b1;
            overflow_in = 1'b1;
         end else begin
            cur_in       = next_free_ff[NODE_W-1:0];
            next_free_in = next_free_ff + 1'b1;
         end
      end
      if (mark_set && (cur_ff == '0)) begin
         root_mark_in = 1'b1;
      end
      if (cmd.respond) begin
         cur_in      = '0;
         missed_in   = 1'b0;
         overflow_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         cur_ff       <= '0;
         next_free_ff <= FREE_W'(1);
         missed_ff    <= 1'b0;
         overflow_ff  <= 1'b0;
         root_mark_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         cur_ff       <= cur_in;
         next_free_ff <= next_free_in;
         missed_ff    <= missed_in;
         overflow_ff  <= overflow_in;
         root_mark_ff <= root_mark_in;
      end
   end

   assign mark_ok = root_sel_ff ? root_mark_ff : mark_rd_ff;

   always_comb begin
      rsp_found     = 1'b0;
      rsp_pool_full = 1'b0;
      if (cmd.respond) begin
         priority if (op_ff == OP_INSERT) begin
            rsp_pool_full = overflow_ff;
         end else if (op_ff == OP_EXACT) begin
            rsp_found = !missed_ff && mark_ok;
         end else begin
            rsp_found = !missed_ff;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/trie_insert_search_unit.sv =====
// Top level of the trie insert and search unit: controller plus datapath.
//
//   channel   ports                                            handshake
//   request   req_opcode, req_letter, req_last_letter,         start, busy
//             req_empty_word
//   result    rsp_found, rsp_pool_full                         rsp_strobe
//
// A letter request runs from accept to the next accept through forming the slot
// address, a synchronous read of the link memory, and following or allocating
// the link. A last-letter request adds a mark memory access and the result
// state. After reset the link memory is cleared one slot per cycle over all
// NODE_COUNT * ALPHABET_SIZE slots, with busy high.
// Results show for one cycle on rsp_strobe and cannot be held off.
`timescale 1ns / 1ps
`default_nettype none

module trie_insert_search_unit
   import tis_pkg::*;
#(
   parameter int NODE_COUNT    = 1024,
   parameter int ALPHABET_SIZE = 26
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [1:0] req_opcode,
   input  wire logic [4:0] req_letter,
   input  wire logic       req_last_letter,
   input  wire logic       req_empty_word,
   output logic            rsp_strobe,
   output logic            rsp_found,
   output logic            rsp_pool_full
);

   tis_cmd_type    cmd;
   tis_status_type status;

   tis_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .status     (status)
   );

   tis_datapath #(
      .NODE_COUNT    (NODE_COUNT),
      .ALPHABET_SIZE (ALPHABET_SIZE)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_opcode      (req_opcode),
      .req_letter      (req_letter),
      .req_last_letter (req_last_letter),
      .req_empty_word  (req_empty_word),
      .rsp_found       (rsp_found),
      .rsp_pool_full   (rsp_pool_full)
   );

endmodule

`default_nettype wire

// ===== rtl/tis_checker.sv =====
// Port-level checker for the trie insert and search unit, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module tis_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_strobe,
   input wire logic rsp_found,
   input wire logic rsp_pool_full
);

   assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");

   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_strobe))
      else $error("accepted request did not raise busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_found || rsp_pool_full) |-> (rsp_strobe && !(rsp_found && rsp_pool_full)))
      else $error("result flags outside a result cycle or both set");

endmodule

bind trie_insert_search_unit tis_checker u_tis_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_strobe    (rsp_strobe),
   .rsp_found     (rsp_found),
   .rsp_pool_full (rsp_pool_full)
);

`default_nettype wire

// ===== tb/trie_insert_search_unit_tb.sv =====
// Self-checking testbench for the trie insert and search unit with a shadow trie scoreboard.
`timescale 1ns / 1ps

module trie_insert_search_unit_tb
   import tis_pkg::*;
();

   localparam int TRIE_NODES   = 1024;
   localparam int TRIE_LETTERS = 26;
   localparam int CYCLE_LIMIT  = 400000;
   localparam logic [1:0] OP_RESERVED = 2'd3;

   typedef struct packed {
      logic found;
      logic pool_full;
   } answer_type;

   typedef struct packed {
      logic [3:0]      len;
      logic [7:0][4:0] ch;
   } word_type;

   class trie_mirror;
      bit [10:0]  links [TRIE_NODES * TRIE_LETTERS];
      bit         marks [TRIE_NODES];
      int         free_node = 1;
      int         node = 0;
      bit         missed = 0;
      bit         overflow = 0;
      answer_type pending [$];
      int         requests = 0;
      int         responses = 0;
      int         hits = 0;
      int         overflows = 0;
      int         failures = 0;

      function void note_request(logic [1:0] op, logic [4:0] letter, bit last, bit empty);
         int         slot;
         int         child;
         answer_type answer;
         requests++;
         if (!empty && !missed) begin
            if (letter >= TRIE_LETTERS) begin
               missed = 1;
            end else begin
               slot  = node * TRIE_LETTERS + letter;
               child = links[slot];
               if (child == 0) begin
                  if (op != OP_INSERT) begin
                     missed = 1;
                  end else if (free_node >= TRIE_NODES) begin
                     missed   = 1;
                     overflow = 1;
                  end else begin
                     child = free_node;
                     free_node++;
                     links[slot]  = child;
                     marks[child] = 0;
                  end
               end
               if (!missed) node = child;
            end
         end
         if (last) begin
            answer = '0;
            if (op == OP_INSERT) begin
               if (!missed) marks[node] = 1;
               answer.pool_full = overflow;
            end else if (op == OP_EXACT) begin
               answer.found = !missed && marks[node];
            end else begin
               answer.found = !missed;
            end
            pending.push_back(answer);
            node     = 0;
            missed   = 0;
            overflow = 0;
         end
      endfunction

      function void check_response(logic found, logic pool_full);
         answer_type want;
         if (pending.size() == 0) begin
            $error("response with none outstanding: found=%b pool_full=%b", found, pool_full);
            failures++;
            return;
         end
         want = pending.pop_front();
         responses++;
         if (want.found) hits++;
         if (want.pool_full) overflows++;
         if (found !== want.found) begin
            $error("found: expected %b, actual %b", want.found, found);
            failures++;
         end
         if (pool_full !== want.pool_full) begin
            $error("pool_full: expected %b, actual %b", want.pool_full, pool_full);
            failures++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [1:0] req_opcode = OP_INSERT;
   logic [4:0] req_letter = '0;
   logic       req_last_letter = 1'b0;
   logic       req_empty_word = 1'b0;
   logic       rsp_strobe;
   logic       rsp_found;
   logic       rsp_pool_full;

   trie_mirror  mirror = new();
   word_type    stored_words [$];
   int          idle_pct = 0;
   int unsigned cycle_count = 0;

   trie_insert_search_unit #(
      .NODE_COUNT   (TRIE_NODES),
      .ALPHABET_SIZE(TRIE_LETTERS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_letter     (req_letter),
      .req_last_letter(req_last_letter),
      .req_empty_word (req_empty_word),
      .rsp_strobe     (rsp_strobe),
      .rsp_found      (rsp_found),
      .rsp_pool_full  (rsp_pool_full)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_strobe !== 1'b0) mirror.check_response(rsp_found, rsp_pool_full);
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[trie_insert_search_unit] ERROR");
         $finish;
      end
   end

   task automatic send_request(logic [1:0] op, logic [4:0] letter, bit last, bit empty);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start           <= 1'b1;
      req_opcode      <= op;
      req_letter      <= letter;
      req_last_letter <= last;
      req_empty_word  <= empty;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      mirror.note_request(op, letter, last, empty);
   endtask

   task automatic hold_until_drained();
      start <= 1'b0;
      while (mirror.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   function automatic word_type make_word(int max_len, int span);
      word_type w;
      w     = '0;
      w.len = 4'($urandom_range(max_len, 1));
      for (int i = 0; i < w.len; i++) w.ch[i] = 5'($urandom_range(span - 1));
      return w;
   endfunction

   function automatic word_type pick_search_word();
      word_type w;
      if (stored_words.size() == 0 || $urandom_range(3) == 0)
         return make_word(6, $urandom_range(1) ? 4 : TRIE_LETTERS);
      w = stored_words[$urandom_range(stored_words.size() - 1)];
      case ($urandom_range(2))
         0: w.len = 4'($urandom_range(w.len, 1));
         1: if (w.len < 8) begin
            w.ch[w.len] = 5'($urandom_range(TRIE_LETTERS - 1));
            w.len++;
         end
         default: ;
      endcase
      return w;
   endfunction

   task automatic send_word(logic [1:0] op, word_type w, int noise_pct);
      logic [1:0] item_op;
      logic [4:0] item_letter;
      bit         close_empty;
      close_empty = $urandom_range(99) < noise_pct / 2;
      for (int i = 0; i < w.len; i++) begin
         item_op     = op;
         item_letter = w.ch[i];
         if ($urandom_range(99) < noise_pct) begin
            case ($urandom_range(2))
               0: item_op = 2'($urandom_range(3));
               1: item_letter = 5'($urandom_range(31, TRIE_LETTERS));
               default: send_request(2'($urandom_range(3)), 5'($urandom_range(31)), 1'b0, 1'b1);
            endcase
         end
         send_request(item_op, item_letter, !close_empty && i == w.len - 1, 1'b0);
      end
      if (close_empty) send_request(op, 5'($urandom_range(31)), 1'b1, 1'b1);
   endtask

   task automatic run_mixed_words(int target, int idle);
      word_type   w;
      int         pick;
      logic [1:0] op;
      idle_pct = idle;
      while (mirror.requests < target) begin
         pick = $urandom_range(99);
         if (pick < 35) begin
            w = make_word(6, $urandom_range(1) ? 4 : TRIE_LETTERS);
            stored_words.push_back(w);
            send_word(OP_INSERT, w, 10);
         end else if (pick < 88) begin
            w  = pick_search_word();
            op = (pick < 60) ? OP_EXACT : ($urandom_range(3) == 0 ? OP_RESERVED : OP_PREFIX);
            send_word(op, w, 10);
         end else begin
            send_request(2'($urandom_range(3)), 5'($urandom_range(31)), 1'b1, 1'b1);
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      idle_pct = 33;

      send_request(OP_EXACT, 5'd0, 1'b1, 1'b1);
      send_request(OP_PREFIX, 5'd31, 1'b1, 1'b1);
      send_request(OP_INSERT, 5'd17, 1'b1, 1'b1);
      send_request(OP_EXACT, 5'd0, 1'b1, 1'b1);
      send_request(OP_INSERT, 5'd0, 1'b0, 1'b0);
      send_request(OP_INSERT, 5'd25, 1'b1, 1'b0);
      send_request(OP_EXACT, 5'd0, 1'b1, 1'b0);
      send_request(OP_PREFIX, 5'd0, 1'b1, 1'b0);
      send_request(OP_EXACT, 5'd0, 1'b0, 1'b0);
      send_request(OP_EXACT, 5'd25, 1'b1, 1'b0);
      send_request(OP_INSERT, 5'd31, 1'b1, 1'b0);
      send_request(OP_EXACT, 5'd26, 1'b1, 1'b0);
      send_request(OP_RESERVED, 5'd0, 1'b0, 1'b0);
      send_request(OP_RESERVED, 5'd25, 1'b1, 1'b0);
      send_request(OP_INSERT, 5'd1, 1'b0, 1'b0);
      send_request(OP_EXACT, 5'd2, 1'b1, 1'b0);
      send_request(OP_PREFIX, 5'd1, 1'b1, 1'b0);
      send_request(OP_INSERT, 5'd3, 1'b0, 1'b0);
      send_request(OP_INSERT, 5'd0, 1'b0, 1'b1);
      send_request(OP_INSERT, 5'd4, 1'b1, 1'b0);
      send_request(OP_EXACT, 5'd16, 1'b0, 1'b0);
      send_request(OP_EXACT, 5'd0, 1'b1, 1'b0);
      send_request(OP_INSERT, 5'd7, 1'b0, 1'b0);
      send_request(OP_INSERT, 5'd0, 1'b1, 1'b1);

      run_mixed_words(150, 33);
      hold_until_drained();
      run_mixed_words(300, 76);
      run_mixed_words(450, 0);
      hold_until_drained();

      $display("covered %0d requests and %0d responses: %0d found, %0d pool full",
               mirror.requests, mirror.responses, mirror.hits, mirror.overflows);
      $display("trie grew to %0d of %0d nodes", mirror.free_node, TRIE_NODES);
      if (mirror.failures == 0) begin
         $display("[trie_insert_search_unit] OK");
      end else begin
         $display("[trie_insert_search_unit] ERROR");
      end
      $finish;
   end

endmodule

// ===== trie_insert_search_unit.f =====
rtl/tis_pkg.sv
rtl/tis_ctrl.sv
rtl/tis_datapath.sv
rtl/trie_insert_search_unit.sv
rtl/tis_checker.sv
tb/trie_insert_search_unit_tb.sv
